@@ rtl/ms_adpcm_pkg.sv @@
// ----------------------------------------------------------------------------
// MS ADPCM stereo decoder package
// Shared constants, command codes, types and coefficient tables.
// ----------------------------------------------------------------------------
package ms_adpcm_pkg;

    localparam int PREAMBLE_BYTES = 14;
    localparam int MIN_BLOCK      = 15;
    localparam int BLOCK_RESET    = 1024;
    localparam int CMD_DEPTH      = 2;
    localparam int OUT_DEPTH      = 2;
    localparam int MAX_SEL        = 6;

    typedef logic [3:0] t_op;

    localparam t_op OP_DATA    = 4'd0;
    localparam t_op OP_SEL_L   = 4'd1;
    localparam t_op OP_SEL_R   = 4'd2;
    localparam t_op OP_DELTA_L = 4'd3;
    localparam t_op OP_DELTA_R = 4'd4;
    localparam t_op OP_NEWER_L = 4'd5;
    localparam t_op OP_NEWER_R = 4'd6;
    localparam t_op OP_OLDER_L = 4'd7;
    localparam t_op OP_OLDER_R = 4'd8;

    typedef struct packed {
        t_op         op;
        logic [15:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] sample;
        logic signed [15:0] delta;
    } t_dec;

    function automatic logic signed [10:0] coef_a(input logic [2:0] sel);
        case (sel)
            3'd0:    return 11'sd256;
            3'd1:    return 11'sd512;
            3'd2:    return 11'sd0;
            3'd3:    return 11'sd192;
            3'd4:    return 11'sd240;
            3'd5:    return 11'sd460;
            default: return 11'sd392;
        endcase
    endfunction

    function automatic logic signed [9:0] coef_b(input logic [2:0] sel);
        case (sel)
            3'd0:    return 10'sd0;
            3'd1:    return -10'sd256;
            3'd2:    return 10'sd0;
            3'd3:    return 10'sd64;
            3'd4:    return 10'sd0;
            3'd5:    return -10'sd208;
            default: return -10'sd232;
        endcase
    endfunction

    function automatic logic [9:0] adapt(input logic [3:0] nib);
        case (nib)
            4'd4:    return 10'd307;
            4'd5:    return 10'd409;
            4'd6:    return 10'd512;
            4'd7:    return 10'd614;
            4'd8:    return 10'd768;
            4'd9:    return 10'd614;
            4'd10:   return 10'd512;
            4'd11:   return 10'd409;
            4'd12:   return 10'd307;
            default: return 10'd230;
        endcase
    endfunction

    // divide by 256, truncating toward zero
    function automatic logic signed [19:0] div256(input logic signed [27:0] v);
        logic signed [19:0] q;
        q = v[27:8];
        if (v[27] && (v[7:0] != 8'd0)) begin
            q = q + 20'sd1;
        end
        return q;
    endfunction

endpackage

@@ rtl/ms_adpcm_stereo_decoder.sv @@
// ----------------------------------------------------------------------------
// MS ADPCM stereo decoder
// Decodes stereo MS ADPCM data-chunk bytes into 16-bit PCM sample pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive i_in_byte and raise push; the word is taken at a clock
//   edge where push is high and full is low. The first word after reset
//   starts a block. Preamble words (14 per block) give no result; every data
//   word gives one left/right pair.
//   Result queue: while empty is low, o_left_sample/o_right_sample hold the
//   oldest pair; raise pop to take it.
//   Config: write block_size on i_cfg_data with i_cfg_valid; o_cfg_ready is
//   always high. Write only while the decoder is idle.
//   Flow: taken words pass the registered command queue to the back end; each
//   data word writes both channels' older samples to the result queue. Throughput:
//   one word per cycle while the result queue has room, set by the per-channel decode.
//   Reset: synchronous, active low; clears the block position, the channel
//   state and both queues, and sets block_size to 1024.
//   Stall: while pop stays low the result queue fills, the back end stops on
//   data words, and full rises once the command queue holds two words.
// ----------------------------------------------------------------------------
module ms_adpcm_stereo_decoder #(
    parameter int CMD_DEPTH = ms_adpcm_pkg::CMD_DEPTH,
    parameter int OUT_DEPTH = ms_adpcm_pkg::OUT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_left_sample,
    output logic [15:0] o_right_sample
);

    import ms_adpcm_pkg::*;

    logic        in_accept;
    logic        cmd_wr;
    t_cmd        cmd_in;
    t_cmd        cmd_out;
    logic        cmd_empty;
    logic        cmd_pop;
    logic        out_wr;
    logic        out_full;
    logic        out_pop;
    logic [15:0] out_left;
    logic [15:0] out_right;
    logic [31:0] out_data;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = push && !full;
    assign out_pop     = pop && !empty;

    ms_adpcm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_in_byte   (i_in_byte),
        .o_cmd_wr    (cmd_wr),
        .o_cmd       (cmd_in)
    );

    ms_adpcm_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_data  (cmd_in),
        .i_rd    (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty),
        .o_full  (full)
    );

    ms_adpcm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_out_ready (!out_full || out_pop),
        .o_out_wr    (out_wr),
        .o_out_left  (out_left),
        .o_out_right (out_right)
    );

    ms_adpcm_fifo #(
        .WIDTH (32),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (out_wr),
        .i_data  ({out_left, out_right}),
        .i_rd    (out_pop),
        .o_data  (out_data),
        .o_empty (empty),
        .o_full  (out_full)
    );

    assign o_left_sample  = out_data[31:16];
    assign o_right_sample = out_data[15:0];

endmodule

@@ rtl/ms_adpcm_fifo.sv @@
// ----------------------------------------------------------------------------
// MS ADPCM small FIFO
// Register-based first-in first-out queue used between the decoder stages.
// ----------------------------------------------------------------------------
module ms_adpcm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        if (p == PW'(DEPTH - 1)) begin
            return '0;
        end
        return p + PW'(1);
    endfunction

    always_comb begin
        n_wptr  = i_wr ? wrap_inc(r_wptr) : r_wptr;
        n_rptr  = i_rd ? wrap_inc(r_rptr) : r_rptr;
        n_count = r_count + CW'(i_wr) - CW'(i_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));

endmodule

@@ rtl/ms_adpcm_front.sv @@
// ----------------------------------------------------------------------------
// MS ADPCM front end
// Tracks the block position, assembles preamble values and issues commands.
// ----------------------------------------------------------------------------
module ms_adpcm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_accept,
    input  logic [7:0]          i_in_byte,
    output logic                o_cmd_wr,
    output ms_adpcm_pkg::t_cmd  o_cmd
);

    import ms_adpcm_pkg::*;

    logic [15:0] r_block_size;
    logic [15:0] r_pos, n_pos;
    logic [7:0]  r_low, n_low;
    logic [15:0] size_eff;
    logic [16:0] pos_inc;
    logic        in_pre;

    always_comb begin
        size_eff = (r_block_size < 16'(MIN_BLOCK)) ? 16'(MIN_BLOCK) : r_block_size;
        pos_inc  = {1'b0, r_pos} + 17'd1;
        in_pre   = (r_pos < 16'(PREAMBLE_BYTES));
        n_pos    = r_pos;
        n_low    = r_low;
        o_cmd_wr = 1'b0;
        o_cmd.op    = OP_DATA;
        o_cmd.value = {8'd0, i_in_byte};
        if (i_accept) begin
            if (in_pre) begin
                n_pos    = pos_inc[15:0];
                o_cmd_wr = 1'b1;
                o_cmd.value = {i_in_byte, r_low};
                case (r_pos[3:0])
                    4'd0: begin
                        o_cmd.op    = OP_SEL_L;
                        o_cmd.value = (i_in_byte > 8'(MAX_SEL)) ? 16'(MAX_SEL)
                                                                : {8'd0, i_in_byte};
                    end
                    4'd1: begin
                        o_cmd.op    = OP_SEL_R;
                        o_cmd.value = (i_in_byte > 8'(MAX_SEL)) ? 16'(MAX_SEL)
                                                                : {8'd0, i_in_byte};
                    end
                    4'd3:  o_cmd.op = OP_DELTA_L;
                    4'd5:  o_cmd.op = OP_DELTA_R;
                    4'd7:  o_cmd.op = OP_NEWER_L;
                    4'd9:  o_cmd.op = OP_NEWER_R;
                    4'd11: o_cmd.op = OP_OLDER_L;
                    4'd13: o_cmd.op = OP_OLDER_R;
                    default: begin
                        o_cmd_wr = 1'b0;
                        n_low    = i_in_byte;
                    end
                endcase
            end else begin
                o_cmd_wr = 1'b1;
                n_pos    = (pos_inc >= {1'b0, size_eff}) ? 16'd0 : pos_inc[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= 16'(BLOCK_RESET);
            r_pos        <= '0;
            r_low        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_block_size <= i_cfg_data;
            end
            r_pos <= n_pos;
            r_low <= n_low;
        end
    end

endmodule

@@ rtl/ms_adpcm_back.sv @@
// ----------------------------------------------------------------------------
// MS ADPCM back end
// Holds per-channel predictor state, loads preamble values, decodes nibbles.
// ----------------------------------------------------------------------------
module ms_adpcm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  ms_adpcm_pkg::t_cmd  i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_out_ready,
    output logic                o_out_wr,
    output logic [15:0]         o_out_left,
    output logic [15:0]         o_out_right
);

    import ms_adpcm_pkg::*;

    logic [2:0]         r_sel   [2];
    logic signed [15:0] r_delta [2];
    logic signed [15:0] r_newer [2];
    logic signed [15:0] r_older [2];
    t_dec               dec     [2];
    logic               is_data;
    logic               fire;

    function automatic t_dec decode(
        input logic [2:0]         sel,
        input logic [3:0]         nib,
        input logic signed [15:0] delta,
        input logic signed [15:0] newer,
        input logic signed [15:0] older
    );
        t_dec               d;
        logic signed [26:0] p1;
        logic signed [25:0] p2;
        logic signed [27:0] psum;
        logic signed [19:0] cd;
        logic signed [20:0] pred;
        logic signed [26:0] dp;
        logic signed [19:0] nd;
        p1   = 27'(newer) * 27'(coef_a(sel));
        p2   = 26'(older) * 26'(coef_b(sel));
        psum = 28'(p1) + 28'(p2);
        cd   = 20'(delta) * 20'($signed(nib));
        pred = 21'(div256(psum)) + 21'(cd);
        if (pred < -21'sd32768) begin
            d.sample = -16'sd32768;
        end else if (pred > 21'sd32767) begin
            d.sample = 16'sd32767;
        end else begin
            d.sample = pred[15:0];
        end
        dp = 27'($signed({1'b0, adapt(nib)})) * 27'(delta);
        nd = div256(28'(dp));
        if (nd < 20'sd16) begin
            d.delta = 16'sd16;
        end else if (nd > 20'sd32767) begin
            d.delta = 16'sd32767;
        end else begin
            d.delta = nd[15:0];
        end
        return d;
    endfunction

    always_comb begin
        dec[0] = decode(r_sel[0], i_cmd.value[7:4], r_delta[0], r_newer[0], r_older[0]);
        dec[1] = decode(r_sel[1], i_cmd.value[3:0], r_delta[1], r_newer[1], r_older[1]);
    end

    assign is_data     = (i_cmd.op == OP_DATA);
    assign fire        = i_cmd_valid && (!is_data || i_out_ready);
    assign o_cmd_pop   = fire;
    assign o_out_wr    = fire && is_data;
    assign o_out_left  = r_older[0];
    assign o_out_right = r_older[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 2; c++) begin
                r_sel[c]   <= '0;
                r_delta[c] <= '0;
                r_newer[c] <= '0;
                r_older[c] <= '0;
            end
        end else if (fire) begin
            case (i_cmd.op)
                OP_DATA: begin
                    for (int c = 0; c < 2; c++) begin
                        r_older[c] <= r_newer[c];
                        r_newer[c] <= dec[c].sample;
                        r_delta[c] <= dec[c].delta;
                    end
                end
                OP_SEL_L:   r_sel[0]   <= i_cmd.value[2:0];
                OP_SEL_R:   r_sel[1]   <= i_cmd.value[2:0];
                OP_DELTA_L: r_delta[0] <= i_cmd.value;
                OP_DELTA_R: r_delta[1] <= i_cmd.value;
                OP_NEWER_L: r_newer[0] <= i_cmd.value;
                OP_NEWER_R: r_newer[1] <= i_cmd.value;
                OP_OLDER_L: r_older[0] <= i_cmd.value;
                OP_OLDER_R: r_older[1] <= i_cmd.value;
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/ms_adpcm_chk.sv @@
// ----------------------------------------------------------------------------
// MS ADPCM decoder checker
// Port-level checks on reset, queue status and result stability.
// ----------------------------------------------------------------------------
module ms_adpcm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [15:0] o_left_sample,
    input logic [15:0] o_right_sample
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    // input side only backs up behind a full result queue
    a_full_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("input queue full while no result word waits");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(o_left_sample) && $stable(o_right_sample)))
        else $error("waiting result word changed or vanished");

endmodule

bind ms_adpcm_stereo_decoder ms_adpcm_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .push           (push),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_left_sample  (o_left_sample),
    .o_right_sample (o_right_sample)
);
